[hw/rtl/gesub_pkg.sv]
// Shared types, constants and helper functions of the geodesic edge subdivision block.
// Depends on nothing; every other file imports it.
package gesub_pkg;

	localparam int COORD_FRAC_BITS = 30;
	localparam int INT_FRAC        = 30;
	localparam int COORD_SH        = COORD_FRAC_BITS - INT_FRAC;
	localparam int MAX_LEVEL       = 64;

	localparam logic [31:0] PI_Q      = 32'd3373259426;
	localparam logic [31:0] HALF_PI_Q = 32'd1686629713;
	localparam logic [30:0] ONE_Q     = 31'h4000_0000;

	localparam logic [7:0] CFG_REFINE_LEVEL = 8'd0;
	localparam logic [7:0] CFG_FIRST_INDEX  = 8'd1;

	typedef logic signed [32:0] coord_t;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
		logic [23:0]        node_index;
		logic               last_of_edge;
	} out_item_t;

	typedef struct packed {
		coord_t [2:0] p0;
		coord_t [2:0] d;
		logic [6:0]   lvl;
	} work_t;

	typedef struct packed {
		logic        load;
		logic [23:0] value;
	} idx_cfg_t;

	typedef enum logic [5:0] {
		S_IDLE, S_SQ, S_SQA, S_L2, S_GAM, S_THE, S_TDIV, S_TDIVD,
		S_NS1, S_NS2, S_NDEN, S_NDEN2, S_NT, S_NPT, S_NPTA, S_NRS, S_NRSA,
		S_NRAD, S_NDIV, S_NDIVD, S_EMIT,
		S_SIN0, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_SIN5,
		S_AC0, S_AC1, S_SQRT, S_DIV0, S_DIV1
	} state_t;

	function automatic logic [31:0] mag33(input coord_t v);
		logic [32:0] m;
		m = v[32] ? (33'd0 - v) : v;
		return m[31:0];
	endfunction

	function automatic coord_t to_internal(input logic signed [31:0] v);
		logic [63:0] m;
		m = {32'd0, (v[31] ? (~v + 32'd1) : v)};
		if (COORD_SH >= 0)
			m = m >> COORD_SH;
		else
			m = m << (-COORD_SH);
		if (m > 64'h8000_0000)
			m = 64'h8000_0000;
		return v[31] ? coord_t'(33'd0 - m[32:0]) : coord_t'(m[32:0]);
	endfunction

	function automatic logic [31:0] from_internal(input coord_t v);
		logic [63:0] m;
		m = {32'd0, mag33(v)};
		if (COORD_SH >= 0)
			m = m << COORD_SH;
		else
			m = m >> (-COORD_SH);
		if (v[32]) begin
			if (m > 64'h8000_0000)
				m = 64'h8000_0000;
		end else begin
			if (m > 64'h7FFF_FFFF)
				m = 64'h7FFF_FFFF;
		end
		return v[32] ? 32'(64'd0 - m) : m[31:0];
	endfunction

	// Taylor divisors (2k)(2k+1) and floor(2^32 / divisor), term k = idx + 1
	function automatic logic [8:0] sin_div(input logic [2:0] idx);
		case (idx)
			3'd0: return 9'd6;
			3'd1: return 9'd20;
			3'd2: return 9'd42;
			3'd3: return 9'd72;
			3'd4: return 9'd110;
			3'd5: return 9'd156;
			3'd6: return 9'd210;
			default: return 9'd272;
		endcase
	endfunction

	function automatic logic [31:0] sin_rcp(input logic [2:0] idx);
		case (idx)
			3'd0: return 32'd715827882;
			3'd1: return 32'd214748364;
			3'd2: return 32'd102261126;
			3'd3: return 32'd59652323;
			3'd4: return 32'd39045157;
			3'd5: return 32'd27531841;
			3'd6: return 32'd20452225;
			default: return 32'd15790320;
		endcase
	endfunction

endpackage

[hw/rtl/gesub_front.sv]
// Front end: accepts edge items, converts endpoints, drops items that yield no node.
// Holds a two-entry work queue toward the back end. Depends on gesub_pkg.
module gesub_front import gesub_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item_in,
	input  logic [6:0] level,
	output logic     wk_valid,
	input  logic     wk_pop,
	output work_t    wk
);

	work_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       acc, wr_en;
	logic [6:0] lvl_c;
	work_t      nw;
	coord_t     p0 [3];
	coord_t     e  [3];
	logic signed [33:0] df [3];

	assign full     = (cnt_q == 2'd2);
	assign wk_valid = (cnt_q != 2'd0);
	assign wk       = mem_q[rd_q];
	assign acc      = push && !full;
	assign lvl_c    = (level > 7'(MAX_LEVEL)) ? 7'(MAX_LEVEL) : level;
	assign wr_en    = acc && (lvl_c > 7'd1);

	always_comb begin
		p0[0] = to_internal(item_in.start_x);
		p0[1] = to_internal(item_in.start_y);
		p0[2] = to_internal(item_in.start_z);
		e[0]  = to_internal(item_in.end_x);
		e[1]  = to_internal(item_in.end_y);
		e[2]  = to_internal(item_in.end_z);
		nw.lvl = lvl_c;
		for (int c = 0; c < 3; c++) begin
			nw.p0[c] = p0[c];
			df[c] = 34'(e[c]) - 34'(p0[c]);
			if (df[c] > 34'sh0_8000_0000)
				nw.d[c] = 33'sh0_8000_0000;
			else if (df[c] < -34'sh0_8000_0000)
				nw.d[c] = 33'sh1_8000_0000;
			else
				nw.d[c] = df[c][32:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_q] <= nw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en)
				wr_q <= ~wr_q;
			if (wk_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(wk_pop);
		end
	end

endmodule

[hw/rtl/gesub_back.sv]
// Back end: sequencer with one shared multiplier, sine, arccosine, square root and divider.
// Emits the interior nodes of each edge into a four-entry result queue. Depends on gesub_pkg.
module gesub_back import gesub_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wk_valid,
	output logic      wk_pop,
	input  work_t     wk,
	input  idx_cfg_t  idx_cfg,
	output logic      empty,
	input  logic      pop,
	output out_item_t item_out
);

	state_t state_q, state_d;
	state_t sin_ret_q, acos_ret_q, sqrt_ret_q, div_ret_q;

	work_t        wk_q;
	logic [1:0]   c_q;
	logic [63:0]  acc_q;
	logic [32:0]  l2_q;
	logic [31:0]  l_q, gamma_q, q0_q, at_q, rad_q;
	logic [6:0]   r0_q, rem_q;
	logic [5:0]   i_q;
	logic signed [32:0] s1_q;
	logic [30:0]  t_q;
	coord_t [2:0] p_q;
	coord_t [2:0] v_q;
	logic [23:0]  next_idx_q;

	logic [31:0]  mul_a, mul_b;
	logic [63:0]  prod_q;

	logic signed [33:0] sarg_q;
	logic [30:0]  sa_q;
	logic         sneg_q;
	logic [31:0]  x2_q, term_q, sv_q, sum_q;
	logic [2:0]   sk_q;
	logic signed [32:0] sres_q;

	logic signed [31:0] ac_c_q;
	logic [31:0]  lo_q, hi_q, mid_q;
	logic [4:0]   ak_q;

	logic [63:0]  sqv_q, sqb_q, sqr_q;

	logic [63:0]  dn_q, dd_q;
	logic [31:0]  dq_q;
	logic [4:0]   dk_q;

	out_item_t    ofifo_q [4];
	logic [1:0]   owr_q, ord_q;
	logic [2:0]   ocnt_q;
	logic         opush, opop, ofull;
	out_item_t    onew;

	logic [33:0]  smag;
	logic [31:0]  sclamp;
	logic [30:0]  sfold;
	logic [31:0]  qe, termn, sumn;
	logic [40:0]  srem;
	logic [32:0]  mid_sum;
	logic [63:0]  sq_trial;
	logic [33:0]  l2_raw;
	logic [32:0]  l2_c;
	logic [33:0]  den;
	logic [31:0]  pr;
	logic signed [34:0] psum;
	coord_t       pnew;
	logic [30:0]  qclamp;
	logic [7:0]   rem_sum;
	logic         last;

	assign ofull = (ocnt_q == 3'd4);
	assign empty = (ocnt_q == 3'd0);
	assign opop  = pop && !empty;
	assign item_out = ofifo_q[ord_q];
	assign last  = (7'(i_q) == wk_q.lvl - 7'd1);

	always_comb begin
		smag    = sarg_q[33] ? 34'(-sarg_q) : 34'(sarg_q);
		sclamp  = (smag > 34'(PI_Q)) ? PI_Q : smag[31:0];
		sfold   = (sclamp > HALF_PI_Q) ? 31'(PI_Q - sclamp) : sclamp[30:0];
		qe      = prod_q[63:32];
		srem    = 41'(sv_q) - 41'(qe) * 41'(sin_div(sk_q));
		termn   = (srem >= 41'(sin_div(sk_q))) ? qe + 32'd1 : qe;
		sumn    = sk_q[0] ? sum_q + termn : sum_q - termn;
		mid_sum = 33'(lo_q) + 33'(hi_q);
		sq_trial = sqr_q + sqb_q;
		l2_raw  = acc_q[63:30];
		l2_c    = (l2_raw > 34'h1_0000_0000) ? 33'h1_0000_0000 : l2_raw[32:0];
		den     = prod_q[63:30];
		pr      = prod_q[61:30];
		psum    = 35'(wk_q.p0[c_q]) +
			(wk_q.d[c_q][32] ? -$signed({3'b000, pr}) : $signed({3'b000, pr}));
		if (psum > 35'sh0_8000_0000)
			pnew = 33'sh0_8000_0000;
		else if (psum < -35'sh0_8000_0000)
			pnew = 33'sh1_8000_0000;
		else
			pnew = psum[32:0];
		qclamp  = (dq_q > 32'h4000_0000) ? ONE_Q : dq_q[30:0];
		rem_sum = 8'(rem_q) + 8'(r0_q);
		onew.new_x        = from_internal(v_q[0]);
		onew.new_y        = from_internal(v_q[1]);
		onew.new_z        = from_internal(v_q[2]);
		onew.node_index   = next_idx_q;
		onew.last_of_edge = last;
	end

	always_comb begin
		state_d = state_q;
		wk_pop  = 1'b0;
		opush   = 1'b0;
		mul_a   = 32'd0;
		mul_b   = 32'd0;
		case (state_q)
			S_IDLE: begin
				if (wk_valid) begin
					wk_pop  = 1'b1;
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				mul_a = mag33(wk_q.d[c_q]);
				mul_b = mag33(wk_q.d[c_q]);
				state_d = S_SQA;
			end
			S_SQA:   state_d = (c_q == 2'd2) ? S_L2 : S_SQ;
			S_L2:    state_d = S_SQRT;
			S_GAM:   state_d = S_AC0;
			S_THE:   state_d = S_AC0;
			S_TDIV:  state_d = S_DIV0;
			S_TDIVD: state_d = S_NS1;
			S_NS1:   state_d = S_SIN0;
			S_NS2:   state_d = S_SIN0;
			S_NDEN: begin
				mul_a = sres_q[31:0];
				mul_b = l_q;
				state_d = (sres_q > 33'sd0 && l_q != 32'd0) ? S_NDEN2 : S_NPT;
			end
			S_NDEN2: state_d = (den != 34'd0 && s1_q > 33'sd0) ? S_DIV0 : S_NPT;
			S_NT:    state_d = S_NPT;
			S_NPT: begin
				mul_a = mag33(wk_q.d[c_q]);
				mul_b = {1'b0, t_q};
				state_d = S_NPTA;
			end
			S_NPTA:  state_d = (c_q == 2'd2) ? S_NRS : S_NPT;
			S_NRS: begin
				mul_a = mag33(p_q[c_q]);
				mul_b = mag33(p_q[c_q]);
				state_d = S_NRSA;
			end
			S_NRSA:  state_d = (c_q == 2'd2) ? S_SQRT : S_NRS;
			S_NRAD:  state_d = (sqr_q == 64'd0) ? S_EMIT : S_NDIV;
			S_NDIV:  state_d = S_DIV0;
			S_NDIVD: state_d = (c_q == 2'd2) ? S_EMIT : S_NDIV;
			S_EMIT: begin
				if (!ofull) begin
					opush   = 1'b1;
					state_d = last ? S_IDLE : S_NS1;
				end
			end
			S_SIN0:  state_d = S_SIN1;
			S_SIN1: begin
				mul_a = {1'b0, sa_q};
				mul_b = {1'b0, sa_q};
				state_d = S_SIN2;
			end
			S_SIN2:  state_d = S_SIN3;
			S_SIN3: begin
				mul_a = term_q;
				mul_b = x2_q;
				state_d = S_SIN4;
			end
			S_SIN4: begin
				mul_a = prod_q[61:30];
				mul_b = sin_rcp(sk_q);
				state_d = S_SIN5;
			end
			S_SIN5:  state_d = (sk_q == 3'd7) ? sin_ret_q : S_SIN3;
			S_AC0:   state_d = S_SIN0;
			S_AC1:   state_d = (ak_q == 5'd31) ? acos_ret_q : S_AC0;
			S_SQRT:  state_d = (sqb_q == 64'd1) ? sqrt_ret_q : S_SQRT;
			S_DIV0:  state_d = (dn_q >= dd_q) ? div_ret_q : S_DIV1;
			S_DIV1:  state_d = (dk_q == 5'd31) ? div_ret_q : S_DIV1;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			S_IDLE: begin
				wk_q  <= wk;
				acc_q <= 64'd0;
				c_q   <= 2'd0;
			end
			S_SQA, S_NRSA: begin
				acc_q <= acc_q + prod_q;
				c_q   <= c_q + 2'd1;
				if (c_q == 2'd2) begin
					sqv_q      <= acc_q + prod_q;
					sqr_q      <= 64'd0;
					sqb_q      <= 64'd1 << 62;
					sqrt_ret_q <= (state_q == S_SQA) ? S_GAM : S_NRAD;
				end
			end
			S_L2: begin
				l2_q <= l2_c;
				if (state_d == S_SQRT) begin
					sqv_q      <= {1'b0, l2_c, 30'd0};
					sqr_q      <= 64'd0;
					sqb_q      <= 64'd1 << 62;
					sqrt_ret_q <= S_GAM;
				end
			end
			S_GAM: begin
				l_q        <= sqr_q[31:0];
				ac_c_q     <= {1'b0, sqr_q[31:1]};
				lo_q       <= 32'd0;
				hi_q       <= PI_Q;
				ak_q       <= 5'd0;
				acos_ret_q <= S_THE;
			end
			S_THE: begin
				gamma_q    <= lo_q;
				ac_c_q     <= 32'(34'sh0_4000_0000 - $signed({2'b00, l2_q[32:1]}));
				lo_q       <= 32'd0;
				hi_q       <= PI_Q;
				ak_q       <= 5'd0;
				acos_ret_q <= S_TDIV;
			end
			S_TDIV: begin
				dn_q      <= 64'(lo_q);
				dd_q      <= 64'(wk_q.lvl) << 31;
				dq_q      <= 32'd0;
				dk_q      <= 5'd0;
				div_ret_q <= S_TDIVD;
			end
			S_TDIVD: begin
				q0_q  <= dq_q;
				r0_q  <= dn_q[6:0];
				at_q  <= dq_q;
				rem_q <= dn_q[6:0];
				i_q   <= 6'd1;
			end
			S_NS1: begin
				sarg_q    <= $signed({2'b00, at_q});
				sin_ret_q <= S_NS2;
			end
			S_NS2: begin
				s1_q      <= sres_q;
				sarg_q    <= $signed({2'b00, PI_Q}) - $signed({2'b00, gamma_q})
					- $signed({2'b00, at_q});
				sin_ret_q <= S_NDEN;
			end
			S_NDEN: begin
				t_q <= 31'd0;
				c_q <= 2'd0;
			end
			S_NDEN2: begin
				dn_q      <= 64'(s1_q[31:0]) << 30;
				dd_q      <= 64'(den[32:0]) << 31;
				dq_q      <= 32'd0;
				dk_q      <= 5'd0;
				div_ret_q <= S_NT;
			end
			S_NT: t_q <= qclamp;
			S_NPTA: begin
				p_q[c_q] <= pnew;
				c_q      <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
				if (c_q == 2'd2)
					acc_q <= 64'd0;
			end
			S_NRAD: begin
				rad_q <= sqr_q[31:0];
				c_q   <= 2'd0;
				if (sqr_q == 64'd0)
					v_q <= '0;
			end
			S_NDIV: begin
				dn_q      <= 64'(mag33(p_q[c_q])) << 30;
				dd_q      <= 64'(rad_q) << 31;
				dq_q      <= 32'd0;
				dk_q      <= 5'd0;
				div_ret_q <= S_NDIVD;
			end
			S_NDIVD: begin
				v_q[c_q] <= p_q[c_q][32] ? coord_t'(33'd0 - 33'(qclamp)) : coord_t'(qclamp);
				c_q      <= c_q + 2'd1;
			end
			S_EMIT: begin
				if (!ofull && !last) begin
					i_q <= i_q + 6'd1;
					if (rem_sum >= 8'(wk_q.lvl)) begin
						rem_q <= 7'(rem_sum - 8'(wk_q.lvl));
						at_q  <= at_q + q0_q + 32'd1;
					end else begin
						rem_q <= rem_sum[6:0];
						at_q  <= at_q + q0_q;
					end
				end
			end
			S_SIN0: begin
				sa_q   <= sfold;
				sneg_q <= sarg_q[33];
			end
			S_SIN2: begin
				x2_q   <= prod_q[61:30];
				term_q <= {1'b0, sa_q};
				sum_q  <= {1'b0, sa_q};
				sk_q   <= 3'd0;
			end
			S_SIN4: sv_q <= prod_q[61:30];
			S_SIN5: begin
				term_q <= termn;
				sum_q  <= sumn;
				sk_q   <= sk_q + 3'd1;
				sres_q <= sneg_q ? -$signed({1'b0, sumn}) : $signed({1'b0, sumn});
			end
			S_AC0: begin
				mid_q     <= mid_sum[32:1];
				sarg_q    <= $signed({2'b00, HALF_PI_Q}) - $signed({2'b00, mid_sum[32:1]});
				sin_ret_q <= S_AC1;
			end
			S_AC1: begin
				if (sres_q > $signed({ac_c_q[31], ac_c_q}))
					lo_q <= mid_q;
				else
					hi_q <= mid_q;
				ak_q <= ak_q + 5'd1;
			end
			S_SQRT: begin
				if (sqv_q >= sq_trial) begin
					sqv_q <= sqv_q - sq_trial;
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else begin
					sqr_q <= sqr_q >> 1;
				end
				sqb_q <= sqb_q >> 2;
			end
			S_DIV0: begin
				if (dn_q >= dd_q)
					dq_q <= 32'h8000_0000;
			end
			S_DIV1: begin
				if (dn_q >= dd_q) begin
					dn_q <= dn_q - dd_q;
					dq_q <= {dq_q[30:0], 1'b1};
				end else begin
					dq_q <= {dq_q[30:0], 1'b0};
				end
				dd_q <= dd_q >> 1;
				dk_q <= dk_q + 5'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (opush)
			ofifo_q[owr_q] <= onew;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q      <= 2'd0;
			ord_q      <= 2'd0;
			ocnt_q     <= 3'd0;
			next_idx_q <= 24'd0;
		end else begin
			if (opush)
				owr_q <= owr_q + 2'd1;
			if (opop)
				ord_q <= ord_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(opush) - 3'(opop);
			if (idx_cfg.load)
				next_idx_q <= idx_cfg.value;
			else if (opush)
				next_idx_q <= next_idx_q + 24'd1;
		end
	end

endmodule

[hw/rtl/geodesic_edge_subdivision_top.sv]
// Top level of the geodesic edge subdivision block: configuration registers,
// front end and back end. Depends on gesub_pkg, gesub_front and gesub_back.
//
// Each accepted edge yields refine_level-1 interior nodes on the great circle (level capped at 64).
// The single sequencer paces the back end: its shared multiplier, bit-serial
// divider and square root serve every step, and a node may skip a division.
// Most of the per-edge setup is the two 32-step arccosine searches, and each
// step runs a sine. The front end takes a new edge while the back end works
// and holds up to two waiting edges. A four-entry queue holds results.
module geodesic_edge_subdivision_top import gesub_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item_in,
	output logic      empty,
	input  logic      pop,
	output out_item_t item_out,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [6:0] level_q;
	logic       wk_valid, wk_pop;
	work_t      wk;
	idx_cfg_t   idx_cfg;

	assign cfg_ready     = 1'b1;
	assign idx_cfg.load  = cfg_valid && (cfg_index == CFG_FIRST_INDEX);
	assign idx_cfg.value = cfg_data[23:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_q <= 7'd1;
		else if (cfg_valid && cfg_index == CFG_REFINE_LEVEL)
			level_q <= cfg_data[6:0];
	end

	gesub_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item_in  (item_in),
		.level    (level_q),
		.wk_valid (wk_valid),
		.wk_pop   (wk_pop),
		.wk       (wk)
	);

	gesub_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wk_valid (wk_valid),
		.wk_pop   (wk_pop),
		.wk       (wk),
		.idx_cfg  (idx_cfg),
		.empty    (empty),
		.pop      (pop),
		.item_out (item_out)
	);

endmodule
